@@ sv/wswd_pkg.sv @@
package wswd_pkg;

   localparam int PROB_W  = 17;
   localparam int RAW_W   = 8;
   localparam int TIME_W  = 48;
   localparam int HITS_W  = 6;
   localparam int THR_W   = 17;
   localparam int MINH_W  = 6;
   localparam int COOL_W  = 32;
   localparam int SCALE_W = 16;
   localparam int ZP_W    = 8;
   localparam int CSR_W   = 32;
   localparam int CSR_IDX_W = 3;

   localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(65536);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HIT_THRESHOLD    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MEAN_MINIMUM     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_HITS         = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_COOLDOWN_US      = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_SCALE      = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_ZERO_POINT = CSR_IDX_W'(5);

   typedef struct packed {
      logic [RAW_W-1:0]  raw_score;
      logic [TIME_W-1:0] time_us;
   } req_type;

   typedef struct packed {
      logic              fired;
      logic [PROB_W-1:0] probability;
      logic [HITS_W-1:0] hit_count;
   } rsp_type;

   typedef struct packed {
      logic [THR_W-1:0]   hit_threshold;
      logic [THR_W-1:0]   mean_minimum;
      logic [MINH_W-1:0]  min_hits;
      logic [COOL_W-1:0]  cooldown_us;
      logic [SCALE_W-1:0] score_scale;
      logic [ZP_W-1:0]    score_zero_point;
   } cfg_type;

   // Classified item handed from the front end to the window logic
   typedef struct packed {
      logic [PROB_W-1:0] probability;
      logic [TIME_W-1:0] time_us;
   } item_type;

endpackage

@@ sv/wake_score_window_detector.sv @@
// Wake score window detector: M-of-N and window-mean detection over a ring of recent scores,
// with a cooldown between detections.
// req channel: one item per classifier inference, carrying the raw 8-bit
//   score and a free-running 48-bit microsecond timestamp.
// rsp channel: exactly one item per request, in order: fired flag, the
//   clamped Q16 probability, and the hit count of the full window (zero until it is full).
// csr port: single-cycle writes of the six threshold/dequantization
//   registers; write only while no request is in flight.
// Pipeline: a request passes the dequantize register, a queue entry and
//   the output register before it shows on rsp_valid.
// Throughput: one item per cycle while rsp_ready is high; the window update (running sum, hit
//   compares, modular time check) is combinational in the back end.
// Stalls: when rsp_ready is low the output register holds its item, the
//   queue fills and the front register keeps taking items until the front
//   register, queue and output register hold four items; then req_ready drops.
// Reset: clears the window, fill count, write index, last fire time and all
//   valid flags, and loads the register reset values. Because the last fire
//   time resets to zero, nothing fires while time_us <= cooldown_us.
module wake_score_window_detector
   import wswd_pkg::*;
#(
   parameter int WINDOW_LEN = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     fe_valid, fe_ready;
   item_type fe_item;
   logic     q_valid, q_ready;
   item_type q_item;

   // Register file: decode index, ignore writes past the list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_HIT_THRESHOLD:    cfg_in.hit_threshold    = csr_wdata[THR_W-1:0];
            CSR_MEAN_MINIMUM:     cfg_in.mean_minimum     = csr_wdata[THR_W-1:0];
            CSR_MIN_HITS:         cfg_in.min_hits         = csr_wdata[MINH_W-1:0];
            CSR_COOLDOWN_US:      cfg_in.cooldown_us      = csr_wdata[COOL_W-1:0];
            CSR_SCORE_SCALE:      cfg_in.score_scale      = csr_wdata[SCALE_W-1:0];
            CSR_SCORE_ZERO_POINT: cfg_in.score_zero_point = csr_wdata[ZP_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hit_threshold    <= THR_W'(39322);
         cfg_ff.mean_minimum     <= THR_W'(32768);
         cfg_ff.min_hits         <= MINH_W'(2);
         cfg_ff.cooldown_us      <= COOL_W'(2000000);
         cfg_ff.score_scale      <= SCALE_W'(256);
         cfg_ff.score_zero_point <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: dequantize and clamp the raw score
   wswd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_valid (fe_valid),
      .out_ready (fe_ready),
      .out_item  (fe_item)
   );

   // Decouple front and back so each can stall on its own
   wswd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_ready  (fe_ready),
      .in_item   (fe_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   // Back: window, detection decision, result register
   wswd_back #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_item   (q_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Pipeline drains on reset
   assert property (@(posedge clock) reset |=> !rsp_valid && !fe_valid && !q_valid)
      else $error("pipeline not empty after reset");

   // Hit count never exceeds the window length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.hit_count <= HITS_W'(WINDOW_LEN))
      else $error("hit count above window length");

   // Clamp keeps probability within 1.0
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.probability <= PROB_ONE)
      else $error("probability above 1.0");

   // Front register holds its item while the queue is full
   assert property (@(posedge clock) disable iff (reset)
      fe_valid && !fe_ready |=> fe_valid && $stable(fe_item))
      else $error("front item lost while queue full");

endmodule

@@ sv/wswd_front.sv @@
module wswd_front
   import wswd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   localparam int PROD_W = SCALE_W + RAW_W;

   logic             valid_ff, valid_in;
   item_type         item_ff, item_in;
   logic [RAW_W-1:0] diff;
   logic [PROD_W-1:0] product;

   assign req_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   // Dequantize and clamp to [0, 1.0]
   always_comb begin
      diff    = req_data.raw_score - cfg.score_zero_point;
      product = PROD_W'(cfg.score_scale) * PROD_W'(diff);
      item_in.time_us = req_data.time_us;
      if (req_data.raw_score < cfg.score_zero_point) begin
         item_in.probability = '0;
      end else if (product > PROD_W'(PROB_ONE)) begin
         item_in.probability = PROB_ONE;
      end else begin
         item_in.probability = product[PROB_W-1:0];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ sv/wswd_queue.sv @@
module wswd_queue
   import wswd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   // Two-entry queue
   logic [1:0] count_ff, count_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   item_type   entry_ff [2];
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in  = count_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

@@ sv/wswd_back.sv @@
module wswd_back
   import wswd_pkg::*;
#(
   parameter int WINDOW_LEN = 5
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   localparam int IDX_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int FILL_W = $clog2(WINDOW_LEN + 1);
   localparam int SUM_W  = PROB_W + $clog2(WINDOW_LEN + 1);

   logic [PROB_W-1:0] window_ff [WINDOW_LEN];
   logic [PROB_W-1:0] window_in [WINDOW_LEN];
   logic [IDX_W-1:0]  widx_ff, widx_in;
   logic [FILL_W-1:0] fill_ff, fill_in, fill_next;
   logic [SUM_W-1:0]  sum_ff, sum_in, sum_next, mean_bar;
   logic [TIME_W-1:0] last_fire_ff, last_fire_in, elapsed;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [WINDOW_LEN-1:0] hit_vec;
   logic [HITS_W-1:0]     hits;
   logic                  take, full, fire;

   assign in_ready  = !rsp_valid_ff || rsp_ready;
   assign take      = in_valid && in_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      // Window after this item's score lands in its slot
      for (int i = 0; i < WINDOW_LEN; i++) begin
         if (IDX_W'(i) == widx_ff) begin
            hit_vec[i] = (in_item.probability >= cfg.hit_threshold);
         end else begin
            hit_vec[i] = (window_ff[i] >= cfg.hit_threshold);
         end
      end
      hits      = HITS_W'($countones(hit_vec));
      sum_next  = sum_ff - SUM_W'(window_ff[widx_ff]) + SUM_W'(in_item.probability);
      mean_bar  = SUM_W'(cfg.mean_minimum) * SUM_W'(WINDOW_LEN);
      fill_next = (fill_ff < FILL_W'(WINDOW_LEN)) ? fill_ff + FILL_W'(1) : fill_ff;
      full      = (fill_next == FILL_W'(WINDOW_LEN));
      elapsed   = in_item.time_us - last_fire_ff;
      fire      = full && (hits >= cfg.min_hits) && (sum_next >= mean_bar)
                  && (elapsed > TIME_W'(cfg.cooldown_us));
   end

   always_comb begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
         window_in[i] = window_ff[i];
      end
      widx_in      = widx_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      last_fire_in = last_fire_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (take) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.fired       = fire;
         rsp_data_in.probability = in_item.probability;
         rsp_data_in.hit_count   = full ? hits : '0;
         widx_in = (widx_ff == IDX_W'(WINDOW_LEN - 1)) ? '0 : widx_ff + IDX_W'(1);
         if (fire) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
               window_in[i] = '0;
            end
            fill_in      = '0;
            sum_in       = '0;
            last_fire_in = in_item.time_us;
         end else begin
            window_in[widx_ff] = in_item.probability;
            fill_in            = fill_next;
            sum_in             = sum_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            window_ff[i] <= '0;
         end
         widx_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         last_fire_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            window_ff[i] <= window_in[i];
         end
         widx_ff      <= widx_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         last_fire_ff <= last_fire_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
